@@ src/upm_pkg.sv @@
// ============================================================================
// upm_pkg
// Shared types, constants and coefficient table for the stereo to surround
// upmixer.
// ============================================================================
package upm_pkg;

    localparam int TAPS_DEF  = 31;
    localparam int TAP_IDX_W = 8;
    localparam int SMP_W     = 32;
    localparam int CLAMP_W   = 31;
    localparam int ACC_W     = 70;
    localparam int CFG_IDX_W = 2;
    localparam int MODE_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_PASS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_220  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_321  = 2'd2;

    localparam logic signed [SMP_W-1:0] Q31_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SMP_W-1:0] Q31_MIN = 32'sh8000_0000;

    localparam logic signed [SMP_W-1:0] HALF_COEF [16] = '{
        -32'sd19982143, -32'sd20273109, -32'sd20551464, -32'sd20816192,
        -32'sd21066252, -32'sd21300580, -32'sd21518086, -32'sd21717660,
        -32'sd21898168, -32'sd22058458, -32'sd22197354, -32'sd22313668,
        -32'sd22406189, -32'sd22473694, -32'sd22514946,  32'sd2105121163
    };

    typedef struct packed {
        logic signed [SMP_W-1:0] left_in;
        logic signed [SMP_W-1:0] right_in;
    } t_in_item;

    typedef struct packed {
        logic signed [SMP_W-1:0] left_out;
        logic signed [SMP_W-1:0] right_out;
        logic signed [SMP_W-1:0] center_out;
        logic signed [SMP_W-1:0] left_surround_out;
        logic signed [SMP_W-1:0] right_surround_out;
        logic signed [SMP_W-1:0] lfe_out;
    } t_out_item;

    typedef struct packed {
        logic smp_load;
        logic gain_en;
        logic wr_en;
        logic acc_clr;
        logic rd_en;
    } t_lane_ctl;

    typedef struct packed {
        logic load;
        logic fir_on;
        logic mix_on;
    } t_mrg_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAIN,
        ST_WRITE,
        ST_MAC,
        ST_DRAIN,
        ST_DONE
    } t_state;

    function automatic logic signed [SMP_W-1:0] f_tap_coef(input logic [TAP_IDX_W-1:0] k);
        logic [TAP_IDX_W-1:0] j;
        j = 8'd30 - k;
        if (k <= 8'd15) begin
            return HALF_COEF[k[3:0]];
        end else if (k <= 8'd30) begin
            return HALF_COEF[j[3:0]];
        end else begin
            return '0;
        end
    endfunction

endpackage

@@ src/upm_ram.sv @@
// ============================================================================
// upm_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module upm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 31,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/upm_lane.sv @@
// ============================================================================
// upm_lane
// One channel lane: gain multiply, delay-line RAM and FIR multiply-accumulate.
// ============================================================================
module upm_lane #(
    parameter int TAPS = 31,
    localparam int AW  = (TAPS > 1) ? $clog2(TAPS) : 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  upm_pkg::t_lane_ctl               i_ctl,
    input  logic signed [upm_pkg::SMP_W-1:0] i_smp,
    input  logic signed [upm_pkg::SMP_W-1:0] i_gain,
    input  logic [AW-1:0]                    i_wr_addr,
    input  logic [AW-1:0]                    i_rd_addr,
    input  logic [AW-1:0]                    i_tap,
    output logic signed [upm_pkg::SMP_W-1:0] o_gained,
    output logic signed [upm_pkg::SMP_W-1:0] o_fir
);

    import upm_pkg::*;

    logic signed [SMP_W-1:0]   r_smp;
    logic signed [SMP_W-1:0]   r_gs;
    logic signed [2*SMP_W-1:0] w_gp;
    logic signed [SMP_W-1:0]   n_gs;

    logic [TAPS-1:0]           r_valid;
    logic                      r_vbit;
    logic                      r_rd_vld;
    logic [AW-1:0]             r_tap;
    logic [SMP_W-1:0]          w_rdata;
    logic signed [SMP_W-1:0]   w_data;
    logic signed [SMP_W-1:0]   w_coef;
    logic signed [2*SMP_W-1:0] w_prod;
    logic signed [2*SMP_W-1:0] r_prod;
    logic                      r_prod_vld;
    logic signed [ACC_W-1:0]   r_acc;

    assign w_gp = r_smp * i_gain;

    always_comb begin
        if (w_gp[63] != w_gp[62]) begin
            n_gs = w_gp[63] ? Q31_MIN : Q31_MAX;
        end else begin
            n_gs = w_gp[62:31];
        end
    end

    upm_ram #(
        .WIDTH(SMP_W),
        .DEPTH(TAPS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_ctl.wr_en),
        .i_waddr(i_wr_addr),
        .i_wdata(r_gs),
        .i_raddr(i_rd_addr),
        .o_rdata(w_rdata)
    );

    assign w_data = r_vbit ? signed'(w_rdata) : '0;
    assign w_coef = f_tap_coef(TAP_IDX_W'(r_tap));
    assign w_prod = w_coef * w_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.smp_load) begin
            r_smp <= i_smp;
        end
        if (i_ctl.gain_en) begin
            r_gs <= n_gs;
        end
        r_vbit <= r_valid[i_rd_addr];
        r_tap  <= i_tap;
        r_prod <= w_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
            r_acc      <= '0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_vld   <= i_ctl.rd_en;
            r_prod_vld <= r_rd_vld;
            if (i_ctl.acc_clr) begin
                r_acc <= '0;
            end else if (r_prod_vld) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    always_comb begin
        if ((&r_acc[ACC_W-1:62]) || !(|r_acc[ACC_W-1:62])) begin
            o_fir = r_acc[62:31];
        end else begin
            o_fir = r_acc[ACC_W-1] ? Q31_MIN : Q31_MAX;
        end
    end

    assign o_gained = r_gs;

endmodule

@@ src/upm_ctrl.sv @@
// ============================================================================
// upm_ctrl
// Sequencer: input handshake, tap walk over the delay lines, write pointer.
// ============================================================================
module upm_ctrl #(
    parameter int TAPS = 31,
    localparam int AW  = (TAPS > 1) ? $clog2(TAPS) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [upm_pkg::MODE_W-1:0]      i_mode,
    input  logic                            i_out_free,
    output upm_pkg::t_lane_ctl              o_lane_ctl,
    output upm_pkg::t_mrg_ctl               o_mrg_ctl,
    output logic [AW-1:0]                   o_wr_addr,
    output logic [AW-1:0]                   o_rd_addr,
    output logic [AW-1:0]                   o_tap
);

    import upm_pkg::*;

    localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

    t_state        r_state, n_state;
    logic [AW-1:0] r_wp, n_wp;
    logic [AW-1:0] r_pos, n_pos;
    logic [AW-1:0] r_k, n_k;
    logic          r_drain, n_drain;
    logic          w_fir_on;
    logic          w_mix_on;

    assign w_fir_on = (i_mode == MODE_220) || (i_mode == MODE_321);
    assign w_mix_on = (i_mode == MODE_321);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wp    <= '0;
            r_pos   <= '0;
            r_k     <= '0;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_pos   <= n_pos;
            r_k     <= n_k;
            r_drain <= n_drain;
        end
    end

    always_comb begin
        n_state           = r_state;
        n_wp              = r_wp;
        n_pos             = r_pos;
        n_k               = r_k;
        n_drain           = r_drain;
        o_in_stall        = 1'b1;
        o_lane_ctl        = '0;
        o_mrg_ctl         = '0;
        o_mrg_ctl.fir_on  = w_fir_on;
        o_mrg_ctl.mix_on  = w_mix_on;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_lane_ctl.smp_load = 1'b1;
                    n_state             = ST_GAIN;
                end
            end
            ST_GAIN: begin
                o_lane_ctl.gain_en = 1'b1;
                n_state            = w_fir_on ? ST_WRITE : ST_DONE;
            end
            ST_WRITE: begin
                o_lane_ctl.wr_en   = 1'b1;
                o_lane_ctl.acc_clr = 1'b1;
                n_pos              = r_wp;
                n_k                = '0;
                n_state            = ST_MAC;
            end
            ST_MAC: begin
                o_lane_ctl.rd_en = 1'b1;
                if (r_k == LAST) begin
                    n_drain = 1'b0;
                    n_state = ST_DRAIN;
                end else begin
                    n_k   = r_k + 1'b1;
                    n_pos = (r_pos == '0) ? LAST : r_pos - 1'b1;
                end
            end
            ST_DRAIN: begin
                if (r_drain) begin
                    n_wp    = (r_wp == LAST) ? '0 : r_wp + 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_drain = 1'b1;
                end
            end
            ST_DONE: begin
                o_mrg_ctl.load = i_out_free;
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_wr_addr = r_wp;
    assign o_rd_addr = r_pos;
    assign o_tap     = r_k;

endmodule

@@ src/upm_merge.sv @@
// ============================================================================
// upm_merge
// Combine lane results into the six-channel frame and hold it for output.
// ============================================================================
module upm_merge (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  upm_pkg::t_mrg_ctl                  i_ctl,
    input  logic signed [upm_pkg::SMP_W-1:0]   i_left,
    input  logic signed [upm_pkg::SMP_W-1:0]   i_right,
    input  logic signed [upm_pkg::SMP_W-1:0]   i_ls,
    input  logic signed [upm_pkg::SMP_W-1:0]   i_rs,
    input  logic [upm_pkg::CLAMP_W-1:0]        i_clamp,
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output upm_pkg::t_out_item                 o_out_data,
    output logic                               o_free
);

    import upm_pkg::*;

    function automatic logic signed [SMP_W-1:0] f_clamp(
        input logic signed [SMP_W:0] v,
        input logic [CLAMP_W-1:0]    lim
    );
        logic signed [SMP_W:0] hi;
        logic signed [SMP_W:0] lo;
        hi = signed'({2'b00, lim});
        lo = -hi;
        if (v > hi) begin
            return hi[SMP_W-1:0];
        end else if (v < lo) begin
            return lo[SMP_W-1:0];
        end else begin
            return v[SMP_W-1:0];
        end
    endfunction

    logic                    r_out_vld;
    t_out_item               r_out;
    t_out_item               n_out;
    logic signed [SMP_W-1:0] w_ls;
    logic signed [SMP_W-1:0] w_rs;
    logic signed [SMP_W:0]   w_lr_sum;
    logic signed [SMP_W:0]   w_sur_sum;

    assign w_ls      = i_ctl.fir_on ? i_ls : '0;
    assign w_rs      = i_ctl.fir_on ? i_rs : '0;
    assign w_lr_sum  = (SMP_W+1)'(i_left) + (SMP_W+1)'(i_right);
    assign w_sur_sum = (SMP_W+1)'(w_ls) + (SMP_W+1)'(w_rs);

    always_comb begin
        n_out                    = '0;
        n_out.left_out           = i_left;
        n_out.right_out          = i_right;
        n_out.left_surround_out  = w_ls;
        n_out.right_surround_out = w_rs;
        if (i_ctl.mix_on) begin
            n_out.center_out = f_clamp(w_lr_sum, i_clamp);
            n_out.lfe_out    = f_clamp(w_sur_sum, i_clamp);
        end
    end

    assign o_free = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_ctl.load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

@@ src/stereo_to_surround_upmix_top.sv @@
// ============================================================================
// stereo_to_surround_upmix_top
// Stereo pair in, six-channel surround frame out.
//
// Input channel: i_in_valid / o_in_stall carry one stereo pair per
// transaction. Output channel: o_out_valid / i_out_stall carry one frame.
// Configuration: i_cfg_we writes gain, clamp level or output mode, selected
// by i_cfg_idx, by the user only while the block is idle (not enforced).
// Processing: a pass-through transaction goes from the gain stage straight to
// the output register; with the surround filters on, it also walks the taps
// through each lane's delay-line RAM, one read per cycle.
// One pair is processed at a time; the next input transaction is taken as
// soon as the finished frame sits in the output register.
// Reset clears the delay lines and write pointer, sets full gain, full clamp
// level and mode 3_2_1. A stall on the output holds the frame; once the
// next frame is ready, it waits inside and the input stays stalled.
// ============================================================================
module stereo_to_surround_upmix_top #(
    parameter int TAPS = upm_pkg::TAPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  upm_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output upm_pkg::t_out_item                o_out_data,
    input  logic                              i_cfg_we,
    input  logic [upm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [upm_pkg::SMP_W-1:0]         i_cfg_wdata
);

    import upm_pkg::*;

    localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;

    logic signed [SMP_W-1:0] r_gain;
    logic [CLAMP_W-1:0]      r_clamp;
    logic [MODE_W-1:0]       r_mode;

    t_lane_ctl               w_lane_ctl;
    t_mrg_ctl                w_mrg_ctl;
    logic [AW-1:0]           w_wr_addr;
    logic [AW-1:0]           w_rd_addr;
    logic [AW-1:0]           w_tap;
    logic                    w_out_free;
    logic signed [SMP_W-1:0] w_left;
    logic signed [SMP_W-1:0] w_right;
    logic signed [SMP_W-1:0] w_ls;
    logic signed [SMP_W-1:0] w_rs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= Q31_MAX;
            r_clamp <= '1;
            r_mode  <= MODE_321;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GAIN:  r_gain  <= signed'(i_cfg_wdata);
                CFG_CLAMP: r_clamp <= i_cfg_wdata[CLAMP_W-1:0];
                CFG_MODE:  r_mode  <= i_cfg_wdata[MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    upm_ctrl #(
        .TAPS(TAPS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_mode    (r_mode),
        .i_out_free(w_out_free),
        .o_lane_ctl(w_lane_ctl),
        .o_mrg_ctl (w_mrg_ctl),
        .o_wr_addr (w_wr_addr),
        .o_rd_addr (w_rd_addr),
        .o_tap     (w_tap)
    );

    upm_lane #(
        .TAPS(TAPS)
    ) u_lane_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_lane_ctl),
        .i_smp    (i_in_data.left_in),
        .i_gain   (r_gain),
        .i_wr_addr(w_wr_addr),
        .i_rd_addr(w_rd_addr),
        .i_tap    (w_tap),
        .o_gained (w_left),
        .o_fir    (w_ls)
    );

    upm_lane #(
        .TAPS(TAPS)
    ) u_lane_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_lane_ctl),
        .i_smp    (i_in_data.right_in),
        .i_gain   (r_gain),
        .i_wr_addr(w_wr_addr),
        .i_rd_addr(w_rd_addr),
        .i_tap    (w_tap),
        .o_gained (w_right),
        .o_fir    (w_rs)
    );

    upm_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_mrg_ctl),
        .i_left     (w_left),
        .i_right    (w_right),
        .i_ls       (w_ls),
        .i_rs       (w_rs),
        .i_clamp    (r_clamp),
        .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .o_free     (w_out_free)
    );

endmodule

@@ dv/tb_stereo_to_surround_upmix_top.sv @@
// ============================================================================
// tb_stereo_to_surround_upmix_top
// Self-checking bench for the stereo to surround upmixer. A clocked driver
// feeds stereo pairs from a queue, and a clocked monitor checks every
// six-channel frame against an in-bench predictor. The predictor covers the
// gain, both surround FIRs with their delay lines, and the clamped center
// and LFE sums. The run has directed extremes, then random phases across all
// output modes and register extremes, with idle and stall bursts, one long
// output hold and one quiet stretch at the end.
// ============================================================================
module tb_stereo_to_surround_upmix_top;
    timeunit 1ns;
    timeprecision 1ps;

    import upm_pkg::*;

    localparam int LINE_LEN = 31;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_PAIRS = 160;
    localparam int HOLD_PHASE = 4;
    localparam int HOLD_CYCLES = 400;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    t_in_item               i_in_data = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    t_out_item              o_out_data;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [SMP_W-1:0]       i_cfg_wdata = '0;

    stereo_to_surround_upmix_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    t_in_item               pair_q[$];
    t_out_item              frame_q[$];

    logic signed [31:0]     cur_gain;
    logic [30:0]            cur_clamp;
    logic [1:0]             cur_mode;
    logic signed [31:0]     dline [2][LINE_LEN];
    int                     line_wp;
    int unsigned            mode_cnt [4];

    int                     errors = 0;
    int                     pairs_sent = 0;
    int                     frames_seen = 0;
    int                     phases_run = 0;
    bit                     src_idle = 1'b0;
    bit                     sink_idle = 1'b0;
    bit                     calm = 1'b0;
    bit                     hold_req = 1'b0;
    bit                     hold_done = 1'b0;
    int                     src_gap = 0;
    int                     sink_gap = 0;
    int                     hold_cnt = 0;
    int                     quiet = 0;

    string                  field_name [6] = '{"lfe_out", "right_surround_out",
                                               "left_surround_out", "center_out",
                                               "right_out", "left_out"};
    logic [5:0][31:0]       exp_w;
    logic [5:0][31:0]       got_w;

    function automatic longint tap_weight(input int k);
        int j;
        j = (k <= 15) ? k : LINE_LEN - 1 - k;
        case (j)
            0:  return -64'sd19982143;
            1:  return -64'sd20273109;
            2:  return -64'sd20551464;
            3:  return -64'sd20816192;
            4:  return -64'sd21066252;
            5:  return -64'sd21300580;
            6:  return -64'sd21518086;
            7:  return -64'sd21717660;
            8:  return -64'sd21898168;
            9:  return -64'sd22058458;
            10: return -64'sd22197354;
            11: return -64'sd22313668;
            12: return -64'sd22406189;
            13: return -64'sd22473694;
            14: return -64'sd22514946;
            default: return 64'sd2105121163;
        endcase
    endfunction

    function automatic logic signed [31:0] sat_q31(input longint v);
        if (v > 64'sd2147483647) begin
            return Q31_MAX;
        end else if (v < -64'sd2147483648) begin
            return Q31_MIN;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] clamp_level(input longint v);
        longint lim;
        lim = cur_clamp;
        if (v > lim) begin
            return lim[31:0];
        end else if (v < -lim) begin
            return -lim[31:0];
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fir_step(input int ch, input logic signed [31:0] smp);
        longint acc;
        int pos;
        acc = 0;
        dline[ch][line_wp] = smp;
        pos = line_wp;
        for (int k = 0; k < LINE_LEN; k++) begin
            acc += tap_weight(k) * longint'(dline[ch][pos]);
            pos = (pos == 0) ? LINE_LEN - 1 : pos - 1;
        end
        return sat_q31(acc >>> 31);
    endfunction

    function automatic t_out_item upmix_frame(input t_in_item p);
        t_out_item f;
        f = '0;
        f.left_out = sat_q31((longint'(p.left_in) * longint'(cur_gain)) >>> 31);
        f.right_out = sat_q31((longint'(p.right_in) * longint'(cur_gain)) >>> 31);
        mode_cnt[cur_mode]++;
        if (cur_mode == MODE_220 || cur_mode == MODE_321) begin
            f.left_surround_out = fir_step(0, f.left_out);
            f.right_surround_out = fir_step(1, f.right_out);
            line_wp = (line_wp == LINE_LEN - 1) ? 0 : line_wp + 1;
            if (cur_mode == MODE_321) begin
                f.center_out = clamp_level(longint'(f.left_out) + longint'(f.right_out));
                f.lfe_out = clamp_level(longint'(f.left_surround_out) +
                                        longint'(f.right_surround_out));
            end
        end
        return f;
    endfunction

    function automatic logic signed [31:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return Q31_MAX;
            1: return Q31_MIN;
            2: return 32'($urandom_range(0, 255)) - 32'd128;
            3, 4: return $signed($urandom()) >>> $urandom_range(1, 12);
            default: return $urandom();
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                frame_q.push_back(upmix_frame(i_in_data));
                pairs_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (src_gap != 0) begin
                    i_in_valid <= 1'b0;
                    src_gap <= src_gap - 1;
                end else if (pair_q.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= pair_q.pop_front();
                    if (src_idle && !calm && $urandom_range(0, 7) == 0) begin
                        src_gap <= $urandom_range(1, 12);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                frames_seen++;
                if (frame_q.size() == 0) begin
                    $display("%0t: surround frame with no expectation pending", $time);
                    errors++;
                end else begin
                    exp_w = frame_q.pop_front();
                    got_w = o_out_data;
                    for (int f = 0; f < 6; f++) begin
                        if (got_w[f] !== exp_w[f]) begin
                            $display("%0t: %s expected %08h got %08h", $time,
                                     field_name[f], exp_w[f], got_w[f]);
                            errors++;
                        end
                    end
                end
            end
            if (hold_cnt != 0) begin
                i_out_stall <= 1'b1;
                hold_cnt <= hold_cnt - 1;
            end else if (hold_req && !hold_done) begin
                hold_done <= 1'b1;
                hold_cnt <= HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else if (sink_gap != 0) begin
                i_out_stall <= 1'b1;
                sink_gap <= sink_gap - 1;
            end else if (sink_idle && !calm && $urandom_range(0, 9) == 0) begin
                i_out_stall <= 1'b1;
                sink_gap <= $urandom_range(0, 11);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet);
            $display("tb_stereo_to_surround_upmix_top failed");
            $finish;
        end
    end

    task automatic push_pair(input logic signed [31:0] l, input logic signed [31:0] r);
        t_in_item p;
        p.left_in = l;
        p.right_in = r;
        pair_q.push_back(p);
    endtask

    task automatic wait_drained();
        while (pair_q.size() != 0 || i_in_valid || frame_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
        phases_run++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_GAIN:  cur_gain = data;
            CFG_CLAMP: cur_clamp = data[30:0];
            CFG_MODE:  cur_mode = data[1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic randomize_regs();
        logic [31:0] g;
        logic [30:0] c;
        logic [1:0] m;
        case ($urandom_range(0, 7))
            0: g = Q31_MAX;
            1: g = Q31_MIN;
            2: g = '0;
            3: g = 32'h4000_0000;
            default: g = $urandom();
        endcase
        case ($urandom_range(0, 5))
            0: c = '0;
            1: c = 31'h7FFF_FFFF;
            2: c = 31'($urandom_range(0, 65535));
            default: c = 31'($urandom());
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: m = MODE_321;
            6, 7: m = MODE_220;
            8: m = MODE_PASS;
            default: m = MODE_UNUSED;
        endcase
        if ($urandom_range(0, 3) == 0) begin
            write_reg(CFG_NONE, $urandom());
        end
        write_reg(CFG_GAIN, g);
        write_reg(CFG_CLAMP, {1'($urandom_range(0, 1)), c});
        write_reg(CFG_MODE, {30'($urandom()), m});
    endtask

    initial begin
        cur_gain = Q31_MAX;
        cur_clamp = 31'h7FFF_FFFF;
        cur_mode = MODE_321;
        line_wp = 0;
        for (int k = 0; k < LINE_LEN; k++) begin
            dline[0][k] = '0;
            dline[1][k] = '0;
        end
        for (int m = 0; m < 4; m++) begin
            mode_cnt[m] = 0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_pair('0, '0);
        push_pair(Q31_MAX, Q31_MAX);
        push_pair(Q31_MIN, Q31_MIN);
        push_pair(Q31_MAX, Q31_MIN);
        push_pair(Q31_MIN, Q31_MAX);
        push_pair(32'sd1, -32'sd1);
        wait_drained();

        // full-scale negative gain times full-scale negative input
        write_reg(CFG_GAIN, Q31_MIN);
        push_pair(Q31_MIN, Q31_MIN);
        push_pair(Q31_MAX, '0);
        push_pair(-32'sd1, 32'sd1);
        wait_drained();

        // pass-through holds the delay lines; index 3 is ignored
        write_reg(CFG_NONE, 32'hFFFF_FFFF);
        write_reg(CFG_MODE, {30'd0, MODE_PASS});
        push_pair(Q31_MIN, Q31_MAX);
        push_pair(32'sd12345, -32'sd12345);
        wait_drained();
        write_reg(CFG_MODE, {30'h3FFF_FFFF, MODE_UNUSED});
        push_pair(32'sh5555_5555, 32'shAAAA_AAAA);
        push_pair(Q31_MAX, Q31_MAX);
        wait_drained();

        write_reg(CFG_MODE, {30'h2AAA_AAAA, MODE_220});
        write_reg(CFG_GAIN, 32'h4000_0000);
        push_pair(Q31_MAX, Q31_MIN);
        push_pair(32'sh0F0F_0F0F, 32'shF0F0_F0F0);
        push_pair(Q31_MIN, Q31_MIN);
        wait_drained();

        write_reg(CFG_MODE, {30'd0, MODE_321});
        write_reg(CFG_CLAMP, '0);
        push_pair(Q31_MAX, Q31_MAX);
        push_pair(Q31_MIN, 32'sd7);
        push_pair(32'sd1000, 32'sd2000);
        wait_drained();
        write_reg(CFG_CLAMP, 32'hFFFF_FFFF);
        write_reg(CFG_GAIN, '0);
        push_pair(Q31_MAX, Q31_MIN);
        push_pair(-32'sd99, 32'sd99);
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            randomize_regs();
            calm = (ph == RAND_PHASES - 1);
            src_idle = (ph % 3 != 2);
            sink_idle = (ph % 4 != 1);
            if (ph == HOLD_PHASE) begin
                hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_PAIRS; n++) begin
                push_pair(rand_sample(), rand_sample());
            end
            wait_drained();
        end
        repeat (40) @(negedge i_clk);

        $display("covered %0d stereo pairs, %0d frames checked, in %0d configuration phases",
                 pairs_sent, frames_seen, phases_run);
        $display("frames per mode: pass %0d, 2_2_0 %0d, 3_2_1 %0d, unused code %0d",
                 mode_cnt[MODE_PASS], mode_cnt[MODE_220], mode_cnt[MODE_321],
                 mode_cnt[MODE_UNUSED]);
        if (errors == 0 && frame_q.size() == 0) begin
            $display("tb_stereo_to_surround_upmix_top passed");
        end else begin
            $display("%0d mismatches, %0d frames still expected", errors, frame_q.size());
            $display("tb_stereo_to_surround_upmix_top failed");
        end
        $finish;
    end

endmodule
